>>> hw/rtl/fsr_pkg.sv
`default_nettype none
package fsr_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(WORD_BITS);
  localparam int unsigned LANES     = 3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_SECRET      = 2'd1,
    CFG_PUBLIC_MARK = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] commitment;
    logic        challenge;
  } in_item_t;

  typedef struct packed {
    logic [31:0] witness;
    logic [31:0] response;
    logic        round_valid;
  } out_item_t;

  // one lane: acc accumulates op times mul, mul consumed msb first
  typedef struct packed {
    word_t acc;
    word_t op;
    word_t mul;
  } lane_t;

  typedef struct packed {
    word_t              n;
    logic               e;
    lane_t [LANES-1:0]  lane;
  } stage_t;

  // (x + y) mod m for x, y < m
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] t;
    s = {1'b0, x} + {1'b0, y};
    t = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      add_mod = t[WORD_BITS-1:0];
    end else begin
      add_mod = s[WORD_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fiat_shamir_round.sv
`default_nettype none
// Fiat-Shamir identification round engine. Each item carries a commitment x and a
// challenge bit e; the result item gives witness a = x*x mod N, response y (x mod N
// for e = 0, x*s mod N for e = 1) and round_valid, set when y*y mod N equals a
// (e = 0) or a*v mod N (e = 1). Modulus, secret and public mark are written
// through the config port (index 0, 1, 2; other indexes are ignored); the user is
// to write them only while the engine is idle, the block does not enforce this.
// A modulus below 2 yields witness 0, response 0, round_valid 1. The datapath is
// a chain of 3*WORD_BITS identical double-and-add cells, one multiplier bit per
// cell: the first row reduces x, s and v mod N, the second forms x*x and x*s, the
// third y*y and a*v. An item enters every cycle while the output is not stalled;
// its result passes through the registers of all 3*WORD_BITS cells, and a stall
// on the output freezes the whole chain.
module fiat_shamir_round (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire fsr_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output fsr_pkg::out_item_t       out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);

  localparam int unsigned W = fsr_pkg::WORD_BITS;

  fsr_pkg::word_t modulus_q, secret_q, mark_q;

  // config registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(2);
      secret_q  <= W'(1);
      mark_q    <= W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fsr_pkg::CFG_MODULUS:     modulus_q <= cfg_data_i[W-1:0];
        fsr_pkg::CFG_SECRET:      secret_q  <= cfg_data_i[W-1:0];
        fsr_pkg::CFG_PUBLIC_MARK: mark_q    <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // the whole chain moves together unless a finished item is held
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // row heads and row outputs
  fsr_pkg::stage_t head [3];
  logic            head_v [3];
  fsr_pkg::stage_t tail [3];
  logic            tail_v [3];

  // row 0: reduce x, s, v by shifting their bits in (op = 1)
  always_comb begin
    head[0]   = '0;
    head_v[0] = in_valid_i;
    head[0].n = modulus_q;
    head[0].e = in_item_i.challenge;
    for (int l = 0; l < fsr_pkg::LANES; l++) begin
      head[0].lane[l].op = W'(1);
    end
    head[0].lane[0].mul = in_item_i.commitment[W-1:0];
    head[0].lane[1].mul = secret_q;
    head[0].lane[2].mul = mark_q;
  end

  // row 1: lane0 x*x, lane1 x*s, lane2 carries v
  always_comb begin
    head[1]             = tail[0];
    head_v[1]           = tail_v[0];
    head[1].lane[0].acc = '0;
    head[1].lane[0].op  = tail[0].lane[0].acc;
    head[1].lane[0].mul = tail[0].lane[0].acc;
    head[1].lane[1].acc = '0;
    head[1].lane[1].op  = tail[0].lane[0].acc;
    head[1].lane[1].mul = tail[0].lane[1].acc;
    head[1].lane[2].acc = '0;
    head[1].lane[2].op  = tail[0].lane[2].acc;
    head[1].lane[2].mul = '0;
  end

  // row 2: lane0 y*y, lane1 a*v (op keeps a), lane2 carries y
  fsr_pkg::word_t y1;
  always_comb begin
    y1 = tail[1].e ? tail[1].lane[1].acc : tail[1].lane[0].op;
    head[2]             = tail[1];
    head_v[2]           = tail_v[1];
    head[2].lane[0].acc = '0;
    head[2].lane[0].op  = y1;
    head[2].lane[0].mul = y1;
    head[2].lane[1].acc = '0;
    head[2].lane[1].op  = tail[1].lane[0].acc;
    head[2].lane[1].mul = tail[1].lane[2].op;
    head[2].lane[2].acc = '0;
    head[2].lane[2].op  = y1;
    head[2].lane[2].mul = '0;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    fsr_pkg::stage_t st [W+1];
    logic            vl [W+1];
    assign st[0] = head[r];
    assign vl[0] = head_v[r];
    for (genvar k = 0; k < W; k++) begin : g_cell
      fsr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (adv),
        .bit_i   (fsr_pkg::IDX_W'(W - 1 - k)),
        .valid_i (vl[k]),
        .stage_i (st[k]),
        .valid_o (vl[k+1]),
        .stage_o (st[k+1])
      );
    end
    assign tail[r]   = st[W];
    assign tail_v[r] = vl[W];
  end

  // result from the last cell; modulus below 2 overrides
  fsr_pkg::word_t rhs;
  logic           small_n;
  always_comb begin
    small_n = (tail[2].n < W'(2));
    rhs     = tail[2].e ? tail[2].lane[1].acc : tail[2].lane[1].op;
    out_item_o = '0;
    if (small_n) begin
      out_item_o.round_valid = 1'b1;
    end else begin
      out_item_o.witness     = 32'(tail[2].lane[1].op);
      out_item_o.response    = 32'(tail[2].lane[2].op);
      out_item_o.round_valid = (tail[2].lane[0].acc == rhs);
    end
  end
  assign out_valid_o = tail_v[2];

endmodule
`default_nettype wire

>>> hw/rtl/fsr_cell.sv
`default_nettype none
module fsr_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic [fsr_pkg::IDX_W-1:0] bit_i,
  input  wire logic                     valid_i,
  input  wire fsr_pkg::stage_t          stage_i,
  output logic                          valid_o,
  output fsr_pkg::stage_t               stage_o
);

  fsr_pkg::stage_t stage_d;
  fsr_pkg::stage_t stage_q;
  logic            valid_q;
  fsr_pkg::word_t  dbl;

  // one double-and-add step per lane
  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < fsr_pkg::LANES; l++) begin
      dbl = fsr_pkg::add_mod(stage_i.lane[l].acc, stage_i.lane[l].acc, stage_i.n);
      if (stage_i.lane[l].mul[bit_i]) begin
        stage_d.lane[l].acc = fsr_pkg::add_mod(dbl, stage_i.lane[l].op, stage_i.n);
      end else begin
        stage_d.lane[l].acc = dbl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire
